// File: rtl/core/chmt_pkg.sv
// Shared types and constants for the cache hit/miss tracker.
package chmt_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned Q_DEPTH = 8;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_STORE = 1'b1
  } kind_e;

  typedef enum logic {
    MODE_DIRECT = 1'b0,
    MODE_ASSOC  = 1'b1
  } mode_e;

  typedef struct packed {
    logic valid;
    logic hit;
    logic mem_write;
  } dir_res_t;

  typedef struct packed {
    logic             hit;
    logic             mem_write;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] write_total;
  } res_t;

endpackage

// File: rtl/core/cache_hit_miss_tracker.sv
// Path: input register s0, set-map stages, directory stage s3, result queue.
// Throughput: one access per cycle while in_ready_o is high; each directory is a
// one-read, one-write memory with a one-deep write forward, and an 8-entry result
// queue decouples the sink. Reset: counters, mode and valid state clear at once;
// a sweep over max(DIRECT_SETS, ASSOC_SETS) addresses (1024 by default) then zeroes
// both directories, in_ready_o low. Top level of the cache hit/miss tracker.
module cache_hit_miss_tracker #(
  parameter int unsigned DIRECT_SETS        = 1024,
  parameter int unsigned ASSOC_SETS         = 512,
  parameter int unsigned DIRECT_OFFSET_BITS = 4,
  parameter int unsigned ASSOC_OFFSET_BITS  = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [chmt_pkg::ADDR_W-1:0] address_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic                        memory_write_o,
  output logic [chmt_pkg::CNT_W-1:0]  miss_total_o,
  output logic [chmt_pkg::CNT_W-1:0]  write_total_o
);

  import chmt_pkg::*;

  localparam int unsigned D_LINE_W = ADDR_W - DIRECT_OFFSET_BITS;
  localparam int unsigned A_LINE_W = ADDR_W - ASSOC_OFFSET_BITS;
  localparam int unsigned D_SET_W  = $clog2(DIRECT_SETS);
  localparam int unsigned A_SET_W  = $clog2(ASSOC_SETS);
  localparam longint unsigned D_TAG_MAX = ((64'd1 << D_LINE_W) - 64'd1) / DIRECT_SETS;
  localparam longint unsigned A_TAG_MAX = ((64'd1 << A_LINE_W) - 64'd1) / ASSOC_SETS;
  localparam int unsigned D_TAG_W  = $clog2(D_TAG_MAX + 1);
  localparam int unsigned A_TAG_W  = $clog2(A_TAG_MAX + 1);

  logic               cache_mode_q;
  logic               in_fire;
  logic               s0_valid_q;
  logic               s1_valid_q;
  logic               s2_valid_q;
  kind_e              s0_kind_q;
  kind_e              s1_kind_q;
  kind_e              s2_kind_q;
  logic [ADDR_W-1:0]  s0_addr_q;
  logic [D_SET_W-1:0] d_set;
  logic [D_TAG_W-1:0] d_tag;
  logic [A_SET_W-1:0] a_set;
  logic [A_TAG_W-1:0] a_tag;
  dir_res_t           dir_res;
  logic               dir_busy;
  logic               room;
  res_t               out_res;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = !dir_busy && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_mode_q <= 1'b0;
      s0_valid_q   <= 1'b0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cache_mode_q <= cfg_wdata_i;
      end
      s0_valid_q <= in_fire;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_kind_q <= kind_e'(kind_i);
      s0_addr_q <= address_i;
    end
    s1_kind_q <= s0_kind_q;
    s2_kind_q <= s1_kind_q;
  end

  chmt_setmap #(
    .SETS   (DIRECT_SETS),
    .LINE_W (D_LINE_W),
    .SET_W  (D_SET_W),
    .TAG_W  (D_TAG_W)
  ) u_dmap (
    .clk_i  (clk_i),
    .line_i (s0_addr_q[ADDR_W-1:DIRECT_OFFSET_BITS]),
    .set_o  (d_set),
    .tag_o  (d_tag)
  );

  chmt_setmap #(
    .SETS   (ASSOC_SETS),
    .LINE_W (A_LINE_W),
    .SET_W  (A_SET_W),
    .TAG_W  (A_TAG_W)
  ) u_amap (
    .clk_i  (clk_i),
    .line_i (s0_addr_q[ADDR_W-1:ASSOC_OFFSET_BITS]),
    .set_o  (a_set),
    .tag_o  (a_tag)
  );

  chmt_dir #(
    .D_SETS  (DIRECT_SETS),
    .A_SETS  (ASSOC_SETS),
    .D_SET_W (D_SET_W),
    .D_TAG_W (D_TAG_W),
    .A_SET_W (A_SET_W),
    .A_TAG_W (A_TAG_W)
  ) u_dir (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_e'(cache_mode_q)),
    .req_valid_i (s2_valid_q),
    .req_kind_i  (s2_kind_q),
    .d_set_i     (d_set),
    .d_tag_i     (d_tag),
    .a_set_i     (a_set),
    .a_tag_i     (a_tag),
    .res_o       (dir_res),
    .busy_o      (dir_busy)
  );

  chmt_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (dir_res),
    .in_fire_i   (in_fire),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign hit_o          = out_res.hit;
  assign memory_write_o = out_res.mem_write;
  assign miss_total_o   = out_res.miss_total;
  assign write_total_o  = out_res.write_total;

endmodule

// File: rtl/core/chmt_setmap.sv
// Line number to set index and tag, by reciprocal multiply with one correction step.
module chmt_setmap #(
  parameter int unsigned SETS   = 1024,
  parameter int unsigned LINE_W = 28,
  parameter int unsigned SET_W  = 10,
  parameter int unsigned TAG_W  = 18
) (
  input  logic              clk_i,
  input  logic [LINE_W-1:0] line_i,
  output logic [SET_W-1:0]  set_o,
  output logic [TAG_W-1:0]  tag_o
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SETS);
  localparam int unsigned RES_W = SET_W + 1;
  localparam int unsigned MUL_W = TAG_W + RES_W;
  localparam logic [RES_W-1:0] SETS_C = RES_W'(SETS);

  logic [LINE_W-1:0]    line1_q;
  logic [LINE_W+31:0]   prod1_q;
  logic [LINE_W-1:0]    line2_q;
  logic [TAG_W-1:0]     quo2_q;
  logic [MUL_W-1:0]     mul2_q;
  logic [TAG_W-1:0]     quo1;
  logic [LINE_W-1:0]    rem_full;
  logic [RES_W-1:0]     rem;
  logic [RES_W-1:0]     rem_adj;
  logic                 over;

  assign quo1 = prod1_q[32 +: TAG_W];

  always_ff @(posedge clk_i) begin
    line1_q <= line_i;
    prod1_q <= (LINE_W + 32)'(line_i) * (LINE_W + 32)'(RECIP);
    line2_q <= line1_q;
    quo2_q  <= quo1;
    mul2_q  <= MUL_W'(quo1) * MUL_W'(SETS_C);
  end

  // quotient estimate is exact or one short
  assign rem_full = line2_q - mul2_q[LINE_W-1:0];
  assign rem      = rem_full[RES_W-1:0];
  assign over     = (rem >= SETS_C);
  assign rem_adj  = over ? (rem - SETS_C) : rem;
  assign set_o    = rem_adj[SET_W-1:0];
  assign tag_o    = quo2_q + TAG_W'(over);

endmodule

// File: rtl/core/chmt_dir.sv
// Tag directories for both modes: memories, clearing sweep, forwarding and update logic.
module chmt_dir #(
  parameter int unsigned D_SETS  = 1024,
  parameter int unsigned A_SETS  = 512,
  parameter int unsigned D_SET_W = 10,
  parameter int unsigned D_TAG_W = 18,
  parameter int unsigned A_SET_W = 9,
  parameter int unsigned A_TAG_W = 17
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  chmt_pkg::mode_e     mode_i,
  input  logic                req_valid_i,
  input  chmt_pkg::kind_e     req_kind_i,
  input  logic [D_SET_W-1:0]  d_set_i,
  input  logic [D_TAG_W-1:0]  d_tag_i,
  input  logic [A_SET_W-1:0]  a_set_i,
  input  logic [A_TAG_W-1:0]  a_tag_i,
  output chmt_pkg::dir_res_t  res_o,
  output logic                busy_o
);

  import chmt_pkg::*;

  localparam int unsigned CLR_N = (D_SETS > A_SETS) ? D_SETS : A_SETS;
  localparam int unsigned CLR_W = $clog2(CLR_N);

  typedef struct packed {
    logic               v;
    logic [D_TAG_W-1:0] tag;
  } d_row_t;

  typedef struct packed {
    logic                    lru;
    logic [1:0]              v;
    logic [1:0]              d;
    logic [1:0][A_TAG_W-1:0] tag;
  } a_row_t;

  d_row_t d_mem [D_SETS];
  a_row_t a_mem [A_SETS];

  logic               clr_busy_q;
  logic [CLR_W-1:0]   clr_addr_q;

  logic               s3_valid_q;
  kind_e              s3_kind_q;
  logic [D_SET_W-1:0] s3_dset_q;
  logic [D_TAG_W-1:0] s3_dtag_q;
  logic [A_SET_W-1:0] s3_aset_q;
  logic [A_TAG_W-1:0] s3_atag_q;

  d_row_t             d_rd_q;
  a_row_t             a_rd_q;
  logic               d_fwd_valid_q;
  logic [D_SET_W-1:0] d_fwd_set_q;
  d_row_t             d_fwd_row_q;
  logic               a_fwd_valid_q;
  logic [A_SET_W-1:0] a_fwd_set_q;
  a_row_t             a_fwd_row_q;

  d_row_t             d_row;
  d_row_t             d_new;
  logic               d_hit;
  logic               d_upd_we;
  a_row_t             a_row;
  a_row_t             a_new;
  logic [1:0]         a_way_hit;
  logic               a_hit;
  logic               a_way;
  logic               a_evict;
  logic               a_upd_we;

  logic               d_we;
  logic [D_SET_W-1:0] d_wa;
  d_row_t             d_wd;
  logic               a_we;
  logic [A_SET_W-1:0] a_wa;
  a_row_t             a_wd;

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + CLR_W'(1);
      if (clr_addr_q == CLR_W'(CLR_N - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q    <= 1'b0;
      d_fwd_valid_q <= 1'b0;
      a_fwd_valid_q <= 1'b0;
    end else begin
      s3_valid_q    <= req_valid_i;
      d_fwd_valid_q <= d_upd_we;
      a_fwd_valid_q <= a_upd_we;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_kind_q   <= req_kind_i;
    s3_dset_q   <= d_set_i;
    s3_dtag_q   <= d_tag_i;
    s3_aset_q   <= a_set_i;
    s3_atag_q   <= a_tag_i;
    d_fwd_set_q <= s3_dset_q;
    d_fwd_row_q <= d_new;
    a_fwd_set_q <= s3_aset_q;
    a_fwd_row_q <= a_new;
  end

  // direct-mapped: write-through, no allocate on store
  always_comb begin
    d_row    = (d_fwd_valid_q && (d_fwd_set_q == s3_dset_q)) ? d_fwd_row_q : d_rd_q;
    d_hit    = d_row.v && (d_row.tag == s3_dtag_q);
    d_new.v   = 1'b1;
    d_new.tag = s3_dtag_q;
    d_upd_we = s3_valid_q && (mode_i == MODE_DIRECT) && (s3_kind_q == KIND_LOAD) && !d_hit;
  end

  // two-way: LRU, write-back, write allocate
  always_comb begin
    a_row        = (a_fwd_valid_q && (a_fwd_set_q == s3_aset_q)) ? a_fwd_row_q : a_rd_q;
    a_way_hit[0] = a_row.v[0] && (a_row.tag[0] == s3_atag_q);
    a_way_hit[1] = a_row.v[1] && (a_row.tag[1] == s3_atag_q);
    a_hit        = |a_way_hit;
    if (a_hit) begin
      a_way = !a_way_hit[0];
    end else if (!a_row.v[0]) begin
      a_way = 1'b0;
    end else if (!a_row.v[1]) begin
      a_way = 1'b1;
    end else begin
      a_way = a_row.lru;
    end
    a_evict = !a_hit && a_row.v[a_way] && a_row.d[a_way];
    a_new   = a_row;
    if (!a_hit) begin
      a_new.tag[a_way] = s3_atag_q;
      a_new.v[a_way]   = 1'b1;
      a_new.d[a_way]   = 1'b0;
    end
    if (s3_kind_q == KIND_STORE) begin
      a_new.d[a_way] = 1'b1;
    end
    a_new.lru = ~a_way;
    a_upd_we  = s3_valid_q && (mode_i == MODE_ASSOC);
  end

  // write port shared between the sweep and updates
  always_comb begin
    if (clr_busy_q) begin
      d_we = ({1'b0, clr_addr_q} < (CLR_W + 1)'(D_SETS));
      d_wa = clr_addr_q[D_SET_W-1:0];
      d_wd = '0;
      a_we = ({1'b0, clr_addr_q} < (CLR_W + 1)'(A_SETS));
      a_wa = clr_addr_q[A_SET_W-1:0];
      a_wd = '0;
    end else begin
      d_we = d_upd_we;
      d_wa = s3_dset_q;
      d_wd = d_new;
      a_we = a_upd_we;
      a_wa = s3_aset_q;
      a_wd = a_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      d_mem[d_wa] <= d_wd;
    end
    d_rd_q <= d_mem[d_set_i];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_wa] <= a_wd;
    end
    a_rd_q <= a_mem[a_set_i];
  end

  assign res_o.valid     = s3_valid_q;
  assign res_o.hit       = (mode_i == MODE_ASSOC) ? a_hit : d_hit;
  assign res_o.mem_write = (mode_i == MODE_ASSOC) ? a_evict : (s3_kind_q == KIND_STORE);
  assign busy_o          = clr_busy_q;

endmodule

// File: rtl/core/chmt_outq.sv
// Saturating miss and write counters, result queue and in-flight tracking.
module chmt_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  chmt_pkg::dir_res_t res_i,
  input  logic               in_fire_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output chmt_pkg::res_t     out_o
);

  import chmt_pkg::*;

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_Q_W = $clog2(Q_DEPTH + 1);

  res_t               q_mem [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [CNT_Q_W-1:0] fill_q;
  logic [CNT_Q_W-1:0] flight_q;
  logic [CNT_W-1:0]   miss_q;
  logic [CNT_W-1:0]   miss_d;
  logic [CNT_W-1:0]   wr_q;
  logic [CNT_W-1:0]   wr_d;
  logic               push;
  logic               pop;
  res_t               entry;

  assign push = res_i.valid;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    miss_d = miss_q;
    wr_d   = wr_q;
    if (push && !res_i.hit && (miss_q != '1)) begin
      miss_d = miss_q + CNT_W'(1);
    end
    if (push && res_i.mem_write && (wr_q != '1)) begin
      wr_d = wr_q + CNT_W'(1);
    end
    entry.hit         = res_i.hit;
    entry.mem_write   = res_i.mem_write;
    entry.miss_total  = miss_d;
    entry.write_total = wr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q   <= '0;
      wr_q     <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      flight_q <= '0;
    end else begin
      miss_q <= miss_d;
      wr_q   <= wr_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      fill_q   <= fill_q + CNT_Q_W'(push) - CNT_Q_W'(pop);
      flight_q <= flight_q + CNT_Q_W'(in_fire_i) - CNT_Q_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= entry;
    end
  end

  // queue holds every item in flight, so the pipeline never stalls
  assign room_o      = (flight_q < CNT_Q_W'(Q_DEPTH));
  assign out_valid_o = (fill_q != '0);
  assign out_o       = q_mem[rd_ptr_q];

endmodule

// File: rtl/core/chmt_checker.sv
// Port-level assertions for the cache hit/miss tracker, with its bind.
module chmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        hit_o,
  input logic        memory_write_o,
  input logic [31:0] miss_total_o,
  input logic [31:0] write_total_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) &&
      $stable(memory_write_o) && $stable(miss_total_o) && $stable(write_total_o))
    else $error("result beat changed while stalled");

  a_miss_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> miss_total_o != 32'd0)
    else $error("miss beat with zero miss count");

  a_write_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && memory_write_o |-> write_total_o != 32'd0)
    else $error("memory write beat with zero write count");

  a_miss_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (miss_total_o == 32'hFFFF_FFFF) |=>
      !out_valid_o || (miss_total_o == 32'hFFFF_FFFF))
    else $error("miss count left saturation");

endmodule

bind cache_hit_miss_tracker chmt_checker u_chmt_checker (.*);

// File: test/cache_hit_miss_tracker_test.sv
// Self-checking testbench for the cache hit/miss tracker, with a scoreboard holding its own tag directories.
`timescale 1ns / 100ps

module cache_hit_miss_tracker_test;
  import chmt_pkg::*;

  localparam int unsigned DM_SETS     = 1024;
  localparam int unsigned SA_SETS     = 512;
  localparam int unsigned DM_OFS      = 4;
  localparam int unsigned SA_OFS      = 6;
  localparam int unsigned DM_SET_W    = 10;
  localparam int unsigned SA_SET_W    = 9;
  localparam int unsigned DM_TAG_W    = ADDR_W - DM_OFS - DM_SET_W;
  localparam int unsigned SA_TAG_W    = ADDR_W - SA_OFS - SA_SET_W;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 155;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned SETTLE      = 8;

  class cache_scoreboard;
    mode_e               mode;
    logic [DM_TAG_W-1:0] dm_tag [DM_SETS];
    bit                  dm_valid [DM_SETS];
    logic [SA_TAG_W-1:0] sa_tag [SA_SETS][2];
    bit                  sa_valid [SA_SETS][2];
    bit                  sa_dirty [SA_SETS][2];
    bit                  sa_lru [SA_SETS];
    logic [CNT_W-1:0]    misses;
    logic [CNT_W-1:0]    writes;
    res_t                due [$];
    int unsigned         errors;

    function new();
      mode   = MODE_DIRECT;
      misses = '0;
      writes = '0;
      errors = 0;
      foreach (dm_tag[i]) begin
        dm_tag[i]   = '0;
        dm_valid[i] = 1'b0;
      end
      foreach (sa_tag[s, w]) begin
        sa_tag[s][w]   = '0;
        sa_valid[s][w] = 1'b0;
        sa_dirty[s][w] = 1'b0;
      end
      foreach (sa_lru[s]) begin
        sa_lru[s] = 1'b0;
      end
    endfunction

    function void note_access(input kind_e k, input logic [ADDR_W-1:0] a);
      res_t                r;
      logic [DM_SET_W-1:0] dset;
      logic [DM_TAG_W-1:0] dtag;
      logic [SA_SET_W-1:0] aset;
      logic [SA_TAG_W-1:0] atag;
      bit                  h0;
      bit                  h1;
      bit                  w;
      r = '0;
      if (mode == MODE_DIRECT) begin
        dset  = a[DM_OFS +: DM_SET_W];
        dtag  = a[ADDR_W-1 -: DM_TAG_W];
        r.hit = dm_valid[dset] && (dm_tag[dset] == dtag);
        if (k == KIND_STORE) begin
          r.mem_write = 1'b1;
        end else if (!r.hit) begin
          dm_tag[dset]   = dtag;
          dm_valid[dset] = 1'b1;
        end
      end else begin
        aset = a[SA_OFS +: SA_SET_W];
        atag = a[ADDR_W-1 -: SA_TAG_W];
        h0   = sa_valid[aset][0] && (sa_tag[aset][0] == atag);
        h1   = sa_valid[aset][1] && (sa_tag[aset][1] == atag);
        if (h0 || h1) begin
          r.hit = 1'b1;
          w     = !h0;
        end else begin
          if (!sa_valid[aset][0]) w = 1'b0;
          else if (!sa_valid[aset][1]) w = 1'b1;
          else w = sa_lru[aset];
          r.mem_write       = sa_valid[aset][w] && sa_dirty[aset][w];
          sa_tag[aset][w]   = atag;
          sa_valid[aset][w] = 1'b1;
          sa_dirty[aset][w] = 1'b0;
        end
        if (k == KIND_STORE) sa_dirty[aset][w] = 1'b1;
        sa_lru[aset] = !w;
      end
      if (!r.hit && misses != '1) misses = misses + 1'b1;
      if (r.mem_write && writes != '1) writes = writes + 1'b1;
      r.miss_total  = misses;
      r.write_total = writes;
      due.push_back(r);
    endfunction

    task report(input string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check_result(input res_t got);
      res_t want;
      if (due.size() == 0) begin
        report($sformatf("result beat with none pending: hit %0b mem_write %0b",
                         got.hit, got.mem_write));
      end else begin
        want = due.pop_front();
        if (got.hit !== want.hit)
          report($sformatf("hit %0b, want %0b", got.hit, want.hit));
        if (got.mem_write !== want.mem_write)
          report($sformatf("memory_write %0b, want %0b", got.mem_write, want.mem_write));
        if (got.miss_total !== want.miss_total)
          report($sformatf("miss_total %0d, want %0d", got.miss_total, want.miss_total));
        if (got.write_total !== want.write_total)
          report($sformatf("write_total %0d, want %0d", got.write_total, want.write_total));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               kind_i;
  logic [ADDR_W-1:0]  address_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               hit_o;
  logic               memory_write_o;
  logic [CNT_W-1:0]   miss_total_o;
  logic [CNT_W-1:0]   write_total_o;

  cache_scoreboard    board;
  int unsigned        send_idle  = 0;
  int unsigned        sink_stall = 0;
  int unsigned        hold_req   = 0;
  logic               sink_hold  = 1'b0;

  cache_hit_miss_tracker u_dut (.*);

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic send_access(input kind_e k, input logic [ADDR_W-1:0] a);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    address_i  <= a;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_access(k, a);
  endtask

  task automatic write_mode(input mode_e m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    board.mode = m;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Narrow tags and sets most of the time so lines collide, hit and get evicted.
  function automatic logic [ADDR_W-1:0] pick_address(input mode_e m);
    logic [ADDR_W-1:0]   a;
    logic [DM_TAG_W-1:0] t;
    logic [DM_SET_W-1:0] s;
    a = $urandom;
    if ($urandom_range(3) != 0) begin
      t = DM_TAG_W'($urandom_range(3));
      s = DM_SET_W'($urandom_range(7));
      if ($urandom_range(1) != 0) t = ~t;
      if ($urandom_range(1) != 0) s = ~s;
      if (m == MODE_DIRECT) begin
        a[ADDR_W-1 -: DM_TAG_W] = t;
        a[DM_OFS +: DM_SET_W]   = s;
      end else begin
        a[ADDR_W-1 -: SA_TAG_W] = t[SA_TAG_W-1:0];
        a[SA_OFS +: SA_SET_W]   = s[SA_SET_W-1:0];
      end
    end
    return a;
  endfunction

  initial begin : sink
    res_t got;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = {hit_o, memory_write_o, miss_total_o, write_total_o};
        board.check_result(got);
      end
      out_ready_i <= !sink_hold && ($urandom_range(99) >= sink_stall);
    end
  end

  // Long receiver hold-off so the result queue fills and the input stalls.
  initial begin : hold_ctl
    int unsigned served;
    served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != served) begin
        served++;
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned n;
    board       = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_LOAD;
    address_i   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);

    // direct-mapped: fill, hit, write-through store, store miss with no allocate, conflict
    write_mode(MODE_DIRECT);
    send_access(KIND_LOAD,  32'h0000_0000);
    send_access(KIND_LOAD,  32'h0000_000F);
    send_access(KIND_STORE, 32'h0000_0004);
    send_access(KIND_STORE, 32'hFFFF_FFFF);
    send_access(KIND_LOAD,  32'hFFFF_FFFF);
    send_access(KIND_LOAD,  32'hFFFF_FFF0);
    send_access(KIND_LOAD,  32'h0000_4000);
    send_access(KIND_LOAD,  32'h0000_0000);
    drain();

    // two-way: fill order, LRU victim, dirty and clean evictions
    write_mode(MODE_ASSOC);
    send_access(KIND_LOAD,  32'h0000_0000);
    send_access(KIND_STORE, 32'h0000_8000);
    send_access(KIND_LOAD,  32'h0000_0000);
    send_access(KIND_LOAD,  32'h0001_0000);
    send_access(KIND_STORE, 32'h0000_0010);
    send_access(KIND_LOAD,  32'h0001_8000);
    send_access(KIND_LOAD,  32'h0002_0000);
    send_access(KIND_STORE, 32'hFFFF_FFFF);
    send_access(KIND_LOAD,  32'hFFFF_FFC0);
    drain();

    // direct-mapped contents survive the mode switch
    write_mode(MODE_DIRECT);
    send_access(KIND_LOAD,  32'h0000_0000);
    send_access(KIND_LOAD,  32'hFFFF_FFFF);

    for (p = 0; p < RAND_PHASES; p++) begin
      drain();
      write_mode(mode_e'(p % 2));
      case (p / 2)
        0: begin
          send_idle = 0;
          sink_stall <= 0;
        end
        1: begin
          send_idle = 58;
          sink_stall <= 0;
        end
        2: begin
          send_idle = 0;
          sink_stall <= 58;
        end
        default: begin
          send_idle = 27;
          sink_stall <= 27;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 20) hold_req <= hold_req + 1;
        send_access(kind_e'($urandom_range(1)), pick_address(board.mode));
      end
    end

    drain();
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: cache_hit_miss_tracker.f
rtl/core/chmt_pkg.sv
rtl/core/chmt_setmap.sv
rtl/core/chmt_dir.sv
rtl/core/chmt_outq.sv
rtl/core/cache_hit_miss_tracker.sv
rtl/core/chmt_checker.sv
test/cache_hit_miss_tracker_test.sv
